// ----- rtl/scrc_pkg.sv -----
// shared types and constants for the sieve composite range counter
`timescale 1ns / 1ps
`default_nettype none

package scrc_pkg;

    // default table top and fixed field widths
    localparam int unsigned SCRC_MAX_VALUE = 65535;
    localparam int unsigned BOUND_W        = 16;
    localparam int unsigned COUNT_W        = 17;
    // widest table address over the parameter range
    localparam int unsigned PFX_ADDR_W     = 20;
    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH    = 2;

    // request payload
    typedef struct packed {
        logic [BOUND_W-1:0] range_low;
        logic [BOUND_W-1:0] range_high;
    } scrc_in_t;

    // result payload
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               bad_range;
    } scrc_out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic               bad;
        logic               lo_zero;
        logic [BOUND_W-1:0] hi;
        logic [BOUND_W-1:0] lo_m1;
    } scrc_cmd_t;

    // prefix table write port driven by the builder
    typedef struct packed {
        logic                  en;
        logic [PFX_ADDR_W-1:0] addr;
        logic [COUNT_W-1:0]    data;
    } scrc_pfx_wr_t;

endpackage

`default_nettype wire

// ----- rtl/scrc_builder.sv -----
// sieve sequencer with its prime map, streams the prefix table after reset
`timescale 1ns / 1ps
`default_nettype none

module scrc_builder
    import scrc_pkg::*;
#(
    parameter int unsigned MAX_VALUE = SCRC_MAX_VALUE
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    output scrc_pfx_wr_t pfx_wr,
    output logic         tables_ready
);

    localparam int unsigned DEPTH = MAX_VALUE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_CHECK,
        ST_TEST,
        ST_MARK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW:0]        sq_reg, sq_next;
    logic [AW:0]        j_reg, j_next;
    logic               issued_reg, issued_next;
    logic               rv_reg, rv_next;
    logic [AW-1:0]      wa_reg, wa_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;

    // prime map: 1 means not marked as a multiple
    logic               map_mem [DEPTH];
    logic               map_rd_reg;
    logic               map_we;
    logic [AW-1:0]      map_wa;
    logic               map_wd;
    logic               map_re;
    logic [AW-1:0]      map_ra;

    logic               counted;
    logic [AW:0]        j_step;
    logic [AW-1:0]      i_inc;
    logic [AW:0]        sq_inc;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_ra];
        end
    end

    // next prime candidate and its square
    assign i_inc  = i_reg + 1'b1;
    assign sq_inc = sq_reg + {i_reg, 1'b1};
    assign j_step = j_reg + (AW+1)'(i_reg);

    // 1 and every composite but 4 are counted; 0 and 1 stay unmarked in the map
    assign counted = (wa_reg == AW'(1)) || (!map_rd_reg && (wa_reg != AW'(4)));

    // sequencer
    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        i_next      = i_reg;
        sq_next     = sq_reg;
        j_next      = j_reg;
        issued_next = issued_reg;
        rv_next     = 1'b0;
        wa_next     = wa_reg;
        acc_next    = acc_reg;
        map_we      = 1'b0;
        map_wa      = addr_reg;
        map_wd      = 1'b1;
        map_re      = 1'b0;
        map_ra      = addr_reg;
        pfx_wr.en   = 1'b0;
        pfx_wr.addr = PFX_ADDR_W'(wa_reg);
        pfx_wr.data = acc_reg + COUNT_W'(counted);
        case (state_reg)
            ST_FILL: begin
                map_we = 1'b1;
                if (addr_reg == AW'(MAX_VALUE)) begin
                    i_next     = AW'(2);
                    sq_next    = (AW+1)'(4);
                    state_next = ST_CHECK;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                if (sq_reg > (AW+1)'(MAX_VALUE)) begin
                    addr_next   = '0;
                    issued_next = 1'b0;
                    acc_next    = '0;
                    state_next  = ST_SCAN;
                end else begin
                    map_re     = 1'b1;
                    map_ra     = i_reg;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (map_rd_reg) begin
                    j_next     = sq_reg;
                    state_next = ST_MARK;
                end else begin
                    i_next     = i_inc;
                    sq_next    = sq_inc;
                    state_next = ST_CHECK;
                end
            end
            ST_MARK: begin
                map_we = 1'b1;
                map_wa = j_reg[AW-1:0];
                map_wd = 1'b0;
                if (j_step > (AW+1)'(MAX_VALUE)) begin
                    i_next     = i_inc;
                    sq_next    = sq_inc;
                    state_next = ST_CHECK;
                end else begin
                    j_next = j_step;
                end
            end
            ST_SCAN: begin
                // issue reads in order, one per cycle
                if (!issued_reg) begin
                    map_re  = 1'b1;
                    map_ra  = addr_reg;
                    rv_next = 1'b1;
                    wa_next = addr_reg;
                    if (addr_reg == AW'(MAX_VALUE)) begin
                        issued_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                // accumulate and write the running count
                if (rv_reg) begin
                    pfx_wr.en = 1'b1;
                    acc_next  = acc_reg + COUNT_W'(counted);
                    if (wa_reg == AW'(MAX_VALUE)) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL;
            addr_reg   <= '0;
            issued_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            issued_reg <= issued_next;
            rv_reg     <= rv_next;
        end
        i_reg   <= i_next;
        sq_reg  <= sq_next;
        j_reg   <= j_next;
        wa_reg  <= wa_next;
        acc_reg <= acc_next;
    end

    assign tables_ready = (state_reg == ST_DONE);

`ifndef NO_ASSERTIONS
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> (state_reg == ST_DONE))
        else $error("table build left the done state");

    a_mark_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> (j_reg <= (AW+1)'(MAX_VALUE)))
        else $error("sieve mark address beyond table");
`endif

endmodule

`default_nettype wire

// ----- rtl/scrc_front.sv -----
// request intake: range check and address prep into a command register
`timescale 1ns / 1ps
`default_nettype none

module scrc_front
    import scrc_pkg::*;
#(
    parameter int unsigned MAX_VALUE = SCRC_MAX_VALUE
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  scrc_in_t       s_data,
    input  wire logic      tables_ready,
    output logic           cmd_valid,
    output scrc_cmd_t      cmd,
    input  wire logic      cmd_ready
);

    logic      cmd_valid_reg, cmd_valid_next;
    scrc_cmd_t cmd_reg, cmd_next;
    logic      take;

    // accept only once tables exist and the command slot frees up
    assign s_ready = tables_ready && (!cmd_valid_reg || cmd_ready);
    assign take    = s_valid && s_ready;

    // classify the request
    always_comb begin
        cmd_next.bad     = (s_data.range_low > s_data.range_high) ||
                           (PFX_ADDR_W'(s_data.range_high) > PFX_ADDR_W'(MAX_VALUE));
        cmd_next.lo_zero = (s_data.range_low == '0);
        cmd_next.hi      = s_data.range_high;
        cmd_next.lo_m1   = s_data.range_low - BOUND_W'(1);
    end

    always_comb begin
        if (take) begin
            cmd_valid_next = 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end else begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ----- rtl/scrc_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module scrc_queue
    import scrc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  scrc_cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output scrc_cmd_t out_cmd
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    scrc_cmd_t     q_mem [QUEUE_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = q_mem[head_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
        if (push) begin
            q_mem[tail_reg] <= in_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

// ----- rtl/scrc_back.sv -----
// prefix table with two read ports, subtract and result register
`timescale 1ns / 1ps
`default_nettype none

module scrc_back
    import scrc_pkg::*;
#(
    parameter int unsigned MAX_VALUE = SCRC_MAX_VALUE
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  scrc_pfx_wr_t pfx_wr,
    input  wire logic    cmd_valid,
    output logic         cmd_ready,
    input  scrc_cmd_t    cmd,
    output logic         m_valid,
    input  wire logic    m_ready,
    output scrc_out_t    m_data
);

    localparam int unsigned DEPTH = MAX_VALUE + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [COUNT_W-1:0] pfx_mem [DEPTH];
    logic [COUNT_W-1:0] rd_hi_reg;
    logic [COUNT_W-1:0] rd_lo_reg;
    logic               bad_reg;
    logic               lo_zero_reg;
    logic               rv_reg, rv_next;
    logic               m_valid_reg, m_valid_next;
    scrc_out_t          m_data_reg, m_data_next;
    logic               out_load;
    logic               pop;

    // stage handshake
    assign out_load  = !m_valid_reg || m_ready;
    assign cmd_ready = !rv_reg || out_load;
    assign pop       = cmd_valid && cmd_ready;

    // table: one write port from the builder, two read ports for lookups
    always_ff @(posedge aclk) begin
        if (pfx_wr.en) begin
            pfx_mem[AW'(pfx_wr.addr)] <= pfx_wr.data;
        end
        if (pop) begin
            rd_hi_reg   <= pfx_mem[AW'(cmd.hi)];
            rd_lo_reg   <= pfx_mem[AW'(cmd.lo_m1)];
            bad_reg     <= cmd.bad;
            lo_zero_reg <= cmd.lo_zero;
        end
    end

    // count: 0 if bad, hi entry if lo is 0, else hi minus lo-1 entry
    always_comb begin
        m_data_next.bad_range = bad_reg;
        if (bad_reg) begin
            m_data_next.count = '0;
        end else if (lo_zero_reg) begin
            m_data_next.count = rd_hi_reg;
        end else begin
            m_data_next.count = rd_hi_reg - rd_lo_reg;
        end
    end

    always_comb begin
        if (pop) begin
            rv_next = 1'b1;
        end else if (out_load) begin
            rv_next = 1'b0;
        end else begin
            rv_next = rv_reg;
        end
        m_valid_next = out_load ? rv_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
        if (out_load && rv_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.bad_range) |-> (m_data_reg.count == '0))
        else $error("rejected range carries a nonzero count");

    a_no_lookup_during_build: assert property (@(posedge aclk) disable iff (!aresetn)
        pfx_wr.en |-> (!cmd_valid && !rv_reg))
        else $error("lookup overlaps prefix table build");
`endif

endmodule

`default_nettype wire

// ----- rtl/sieve_composite_range_counter.sv -----
// Range counter of non-prime values backed by a sieve-built prefix table.
// Requests (s_valid/s_ready/s_data) carry an inclusive range_low..range_high;
// each returns one result (m_valid/m_ready/m_data) with the number of
// counted values (1 and every composite except 4) in that range, or a count
// of 0 with bad_range set when range_low > range_high or range_high > MAX_VALUE.
// After aresetn the block builds its tables and holds s_ready low meanwhile:
// a fill of all MAX_VALUE+1 map entries, the sieve (a test of each candidate
// up to sqrt(MAX_VALUE), plus a mark of each multiple from p*p for each
// prime p), then a prefix scan of the whole table.
// After that one request is taken per cycle while m_ready does not stall the output.
// A request passes through the command register, the queue, the
// registered read of the dual-read-port prefix table and the result register.
// The front and back stages are split by a two-entry command queue, so a
// stall on m_ready fills the result register, the read stage, the queue and
// the command register before s_ready drops; no result is lost or repeated
// under any stall pattern.
`timescale 1ns / 1ps
`default_nettype none

module sieve_composite_range_counter
    import scrc_pkg::*;
#(
    parameter int unsigned MAX_VALUE = SCRC_MAX_VALUE
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  scrc_in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output scrc_out_t m_data
);

    scrc_pfx_wr_t pfx_wr;
    logic         tables_ready;
    logic         f_valid;
    logic         f_ready;
    scrc_cmd_t    f_cmd;
    logic         q_valid;
    logic         q_ready;
    scrc_cmd_t    q_cmd;

    scrc_builder #(
        .MAX_VALUE (MAX_VALUE)
    ) u_builder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pfx_wr       (pfx_wr),
        .tables_ready (tables_ready)
    );

    scrc_front #(
        .MAX_VALUE (MAX_VALUE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .tables_ready (tables_ready),
        .cmd_valid    (f_valid),
        .cmd          (f_cmd),
        .cmd_ready    (f_ready)
    );

    scrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    scrc_back #(
        .MAX_VALUE (MAX_VALUE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pfx_wr    (pfx_wr),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- bench/range_count_checker.sv -----
// request/result monitor with a sieve-built prediction of range counts
`timescale 1ns / 1ps

module range_count_checker
    import scrc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  scrc_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  scrc_out_t m_data,
    output int        fail_count,
    output int        pending_count
);

    // the one composite that is left out of the count
    localparam int unsigned SKIPPED_COMPOSITE = 4;

    bit                 composite [0:SCRC_MAX_VALUE];
    logic [COUNT_W-1:0] counted_upto [0:SCRC_MAX_VALUE];
    scrc_out_t          expected_counts [$];
    int                 mismatches = 0;
    int                 waiting = 0;

    assign fail_count    = mismatches;
    assign pending_count = waiting;

    // sieve the table range, then running count of 1 and composites except 4
    initial begin
        int unsigned i;
        int unsigned j;
        logic [COUNT_W-1:0] running;
        for (i = 0; i <= SCRC_MAX_VALUE; i++) composite[i] = 1'b0;
        for (i = 2; i * i <= SCRC_MAX_VALUE; i++) begin
            if (!composite[i]) begin
                for (j = i * i; j <= SCRC_MAX_VALUE; j += i) composite[j] = 1'b1;
            end
        end
        running = '0;
        for (i = 0; i <= SCRC_MAX_VALUE; i++) begin
            if (i == 1 || (composite[i] && i != SKIPPED_COMPOSITE)) running++;
            counted_upto[i] = running;
        end
    end

    // expected answer for one range request
    function automatic scrc_out_t predict_range_count(scrc_in_t req);
        scrc_out_t          res;
        logic [COUNT_W-1:0] below;
        res = '0;
        if (req.range_low > req.range_high || req.range_high > SCRC_MAX_VALUE) begin
            res.bad_range = 1'b1;
        end else begin
            below = (req.range_low == 0) ? '0 : counted_upto[req.range_low - 1];
            res.count = counted_upto[req.range_high] - below;
        end
        return res;
    endfunction

    // results are matched first, since none can belong to a request taken this edge
    always @(posedge aclk) begin
        scrc_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $error("result with no request waiting: count %0d, bad_range %0b",
                           m_data.count, m_data.bad_range);
                    mismatches++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_data.count !== want.count) begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, m_data.count);
                        mismatches++;
                    end
                    if (m_data.bad_range !== want.bad_range) begin
                        $error("bad_range mismatch: expected %0b, got %0b",
                               want.bad_range, m_data.bad_range);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) expected_counts.push_back(predict_range_count(s_data));
            waiting = expected_counts.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// top of the range counter bench: clock, reset, request stream and verdict
`timescale 1ns / 1ps

module testbench
    import scrc_pkg::*;
();

    // nothing is accepted during the table build after reset
    localparam int STALL_LIMIT   = 1_600_000;
    localparam int RANDOM_ITEMS  = 1280;
    localparam int QUIET_TAIL    = 200;
    localparam int DIRECTED_N    = 18;
    localparam int DRAIN_CYCLES  = 16;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    scrc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    scrc_out_t m_data;
    int        fail_count;
    int        pending_count;

    bit        idle_on = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    always #5 aclk = ~aclk;

    sieve_composite_range_counter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    range_count_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // result side back-pressure in random bursts, started only while idling is on
    always @(negedge aclk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one request from a falling edge, after a random idle gap while idling is on, and hold it until taken
    task automatic send_request(input scrc_in_t req);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // random range shaped toward narrow, low-end, wide, reversed, single-value and unconstrained cases
    function automatic scrc_in_t pick_range();
        scrc_in_t req;
        int       kind;
        int       lo;
        int       hi;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            lo = $urandom_range(0, 65535);
            hi = lo + $urandom_range(0, 64);
            if (hi > 65535) hi = 65535;
        end else if (kind < 55) begin
            lo = $urandom_range(0, 32);
            hi = lo + $urandom_range(0, 40);
        end else if (kind < 75) begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(lo, 65535);
        end else if (kind < 85) begin
            lo = $urandom_range(1, 65535);
            hi = $urandom_range(0, lo - 1);
        end else if (kind < 92) begin
            lo = $urandom_range(0, 65535);
            hi = lo;
        end else begin
            lo = $urandom & 16'hFFFF;
            hi = $urandom & 16'hFFFF;
        end
        req.range_low  = lo[BOUND_W-1:0];
        req.range_high = hi[BOUND_W-1:0];
        return req;
    endfunction

    initial begin
        logic [BOUND_W-1:0] edge_lo [DIRECTED_N];
        logic [BOUND_W-1:0] edge_hi [DIRECTED_N];
        scrc_in_t req;
        int i;

        // field extremes, the values 0, 1 and 4, primes only, reversed ranges;
        // a bound above the table top cannot occur at the default 16-bit size
        edge_lo = '{16'd0, 16'd0, 16'd65535, 16'd1, 16'd4, 16'd0, 16'd4, 16'd5,
                    16'd65535, 16'd2, 16'd8, 16'd0, 16'd65534, 16'd100, 16'd1000,
                    16'd0, 16'd3, 16'd1};
        edge_hi = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'd4, 16'd4, 16'd5, 16'd4,
                    16'd0, 16'd3, 16'd10, 16'd1, 16'd65535, 16'd200, 16'd999,
                    16'd5, 16'd3, 16'd65535};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests
        for (i = 0; i < DIRECTED_N; i++) begin
            req.range_low  = edge_lo[i];
            req.range_high = edge_hi[i];
            send_request(req);
        end

        // random requests, idling switched off in some stretches and at the end
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 3 != 2);
            send_request(pick_range());
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
